FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define PKF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pkf_pkg.sv
// Types, constants and helpers of the pose Kalman filter.
`default_nettype none

package pkf_pkg;

   localparam int DATA_W     = 32;
   localparam int ELAPSED_W  = 48;
   localparam int AXES_MAX   = 3;
   localparam int AXES_DEF   = 3;
   localparam int AXIS_SEL_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int GAIN_W     = 17;
   localparam int DVD_W      = 49;
   localparam int DSR_W      = 33;
   localparam int GAIN_BITS  = 17;
   localparam int VEL_BITS   = 32;
   localparam int DIV_CNT_W  = $clog2(VEL_BITS + 1);

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

   localparam logic [CSR_IDX_W-1:0] REG_Q_POS_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Q_POS_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Q_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_R_POS_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_R_POS_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_R_HEADING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_GAIN,
      ST_GAIN_WAIT,
      ST_CORR_MUL,
      ST_CORR,
      ST_COV_MUL,
      ST_COV,
      ST_VEL,
      ST_VEL_WAIT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic start;
      logic long_mode;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_sts_type;

   function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [39:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 40'sh00_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sh00_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/pkf_divider.sv
// Shared restoring divider, one quotient bit per cycle, 17 or 32 bit quotient.
`default_nettype none

module pkf_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pkf_pkg::div_cmd_type           cmd,
   input  wire logic [pkf_pkg::DVD_W-1:0]      dividend,
   input  wire logic [pkf_pkg::DSR_W-1:0]      divisor,
   output pkf_pkg::div_sts_type                sts,
   output logic [pkf_pkg::VEL_BITS-1:0]        quotient
);

   logic [pkf_pkg::DSR_W-1:0]     rem_ff, rem_in;
   logic [pkf_pkg::DSR_W-1:0]     dsr_ff;
   logic [pkf_pkg::VEL_BITS-1:0]  dvd_ff, quo_ff;
   logic [pkf_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff, done_ff, ovf_ff;
   logic [pkf_pkg::DSR_W:0]       trial, diff;
   logic                          ge;
   logic [pkf_pkg::DSR_W-1:0]     start_rem;

   always_comb begin
      trial  = {rem_ff, dvd_ff[pkf_pkg::VEL_BITS-1]};
      diff   = trial - {1'b0, dsr_ff};
      ge     = (trial >= {1'b0, dsr_ff});
      rem_in = ge ? diff[pkf_pkg::DSR_W-1:0] : trial[pkf_pkg::DSR_W-1:0];
      if (cmd.long_mode) begin
         start_rem = pkf_pkg::DSR_W'(dividend[pkf_pkg::DVD_W-1:pkf_pkg::VEL_BITS]);
      end else begin
         start_rem = pkf_pkg::DSR_W'(dividend[pkf_pkg::DVD_W-1:pkf_pkg::GAIN_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         rem_ff  <= start_rem;
         dsr_ff  <= divisor;
         ovf_ff  <= (start_rem >= divisor);
         quo_ff  <= '0;
         if (cmd.long_mode) begin
            dvd_ff <= dividend[pkf_pkg::VEL_BITS-1:0];
            cnt_ff <= pkf_pkg::DIV_CNT_W'(pkf_pkg::VEL_BITS);
         end else begin
            dvd_ff <= {dividend[pkf_pkg::GAIN_BITS-1:0],
                       (pkf_pkg::VEL_BITS - pkf_pkg::GAIN_BITS)'(0)};
            cnt_ff <= pkf_pkg::DIV_CNT_W'(pkf_pkg::GAIN_BITS);
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[pkf_pkg::VEL_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[pkf_pkg::VEL_BITS-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == pkf_pkg::DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign sts.done     = done_ff;
   assign sts.overflow = ovf_ff;
   assign quotient     = quo_ff;

endmodule

`default_nettype wire

FILE: sv/pose_kalman_filter.sv
// Top level of the three-axis pose Kalman filter with a shared divider and multiplier.
// One request at a time: req_stall stays high from accept until the result
// is loaded into the output register, so no new item is taken before then.
// Reset (synchronous): estimate 0, covariance 1.0, elapsed 0, all registers 1.0.
`default_nettype none

module pose_kalman_filter #(
   parameter int AXES = pkf_pkg::AXES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pkf_pkg::DATA_W-1:0]   req_meas_x,
   input  wire logic signed [pkf_pkg::DATA_W-1:0]   req_meas_y,
   input  wire logic signed [pkf_pkg::DATA_W-1:0]   req_meas_heading,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_est_x,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_est_y,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_est_heading,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_vel_x,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_vel_y,
   output logic signed [pkf_pkg::DATA_W-1:0]        rsp_disp_sum,
   output logic [pkf_pkg::ELAPSED_W-1:0]            rsp_elapsed,
   input  wire logic                                csr_we,
   input  wire logic [pkf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pkf_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int DW     = pkf_pkg::DATA_W;

   pkf_pkg::state_type state_ff, state_in;

   logic [DW-1:0]        q_ff [pkf_pkg::AXES_MAX];
   logic [DW-1:0]        r_ff [pkf_pkg::AXES_MAX];
   logic [DW-1:0]        ts_ff;
   logic signed [DW-1:0] z_ff [pkf_pkg::AXES_MAX];
   logic signed [DW-1:0] est_ff [AXES];
   logic [DW-1:0]        cov_ff [AXES];
   logic signed [DW-1:0] pose [pkf_pkg::AXES_MAX];
   logic signed [DW-1:0] old_x_ff, old_y_ff;
   logic [AXIS_W-1:0]    axis_ff;
   logic                 vel_sel_ff;
   logic [DW-1:0]        p_ff;
   logic                 den_zero_ff;
   logic [pkf_pkg::GAIN_W-1:0] k_ff;
   logic signed [51:0]   prod_ff;
   logic signed [DW-1:0] vel_ff [2];
   logic                 vel_neg_ff, vel_zero_ff;
   logic [pkf_pkg::ELAPSED_W-1:0] time_acc_ff;
   logic                 rsp_valid_ff;

   logic accept, ld_p, ld_k, ld_prod, mul_cov, ld_est, ld_cov, ld_vel, ld_rsp;
   logic last_axis;
   pkf_pkg::div_cmd_type div_cmd;
   pkf_pkg::div_sts_type div_sts;
   logic [pkf_pkg::VEL_BITS-1:0] div_quo;
   logic [pkf_pkg::DVD_W-1:0] div_dvd;
   logic [pkf_pkg::DSR_W-1:0] div_dsr;

   logic [pkf_pkg::AXIS_SEL_W-1:0] axis_sel;
   logic [DW:0]          pred_sum;
   logic [DW-1:0]        p_pred;
   logic [DW:0]          den;
   logic signed [DW:0]   diff;
   logic [pkf_pkg::GAIN_W-1:0] k_comp;
   logic signed [17:0]   mul_a;
   logic signed [33:0]   mul_b;
   logic signed [51:0]   product;
   logic signed [51:0]   rounded;
   logic signed [35:0]   corr;
   logic signed [36:0]   est_sum;
   logic signed [DW-1:0] vel_cur, vel_old;
   logic signed [DW:0]   delta;
   logic [DW:0]          mag;
   logic signed [DW-1:0] vel_val;
   logic signed [DW:0]   dx, dy;
   logic signed [DW+1:0] dsum;

   for (genvar g = 0; g < pkf_pkg::AXES_MAX; g++) begin : g_pose
      if (g < AXES) begin : g_on
         assign pose[g] = est_ff[g];
      end else begin : g_off
         assign pose[g] = '0;
      end
   end

   assign axis_sel  = pkf_pkg::AXIS_SEL_W'(axis_ff);
   assign last_axis = (axis_ff == AXIS_W'(AXES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pkf_pkg::ST_IDLE:      if (accept) state_in = pkf_pkg::ST_PREDICT;
         pkf_pkg::ST_PREDICT:   state_in = pkf_pkg::ST_GAIN;
         pkf_pkg::ST_GAIN:      state_in = pkf_pkg::ST_GAIN_WAIT;
         pkf_pkg::ST_GAIN_WAIT: if (div_sts.done) state_in = pkf_pkg::ST_CORR_MUL;
         pkf_pkg::ST_CORR_MUL:  state_in = pkf_pkg::ST_CORR;
         pkf_pkg::ST_CORR:      state_in = pkf_pkg::ST_COV_MUL;
         pkf_pkg::ST_COV_MUL:   state_in = pkf_pkg::ST_COV;
         pkf_pkg::ST_COV:       state_in = last_axis ? pkf_pkg::ST_VEL : pkf_pkg::ST_PREDICT;
         pkf_pkg::ST_VEL:       state_in = pkf_pkg::ST_VEL_WAIT;
         pkf_pkg::ST_VEL_WAIT: begin
            if (div_sts.done) begin
               state_in = vel_sel_ff ? pkf_pkg::ST_OUTPUT : pkf_pkg::ST_VEL;
            end
         end
         pkf_pkg::ST_OUTPUT:    if (ld_rsp) state_in = pkf_pkg::ST_IDLE;
         default:               state_in = pkf_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall         = reset || (state_ff != pkf_pkg::ST_IDLE);
      accept            = req_valid && !req_stall;
      ld_p              = (state_ff == pkf_pkg::ST_PREDICT);
      div_cmd.start     = (state_ff == pkf_pkg::ST_GAIN) || (state_ff == pkf_pkg::ST_VEL);
      div_cmd.long_mode = (state_ff == pkf_pkg::ST_VEL);
      ld_k              = (state_ff == pkf_pkg::ST_GAIN_WAIT) && div_sts.done;
      ld_prod           = (state_ff == pkf_pkg::ST_CORR_MUL) || (state_ff == pkf_pkg::ST_COV_MUL);
      mul_cov           = (state_ff == pkf_pkg::ST_COV_MUL);
      ld_est            = (state_ff == pkf_pkg::ST_CORR);
      ld_cov            = (state_ff == pkf_pkg::ST_COV);
      ld_vel            = (state_ff == pkf_pkg::ST_VEL_WAIT) && div_sts.done;
      ld_rsp            = (state_ff == pkf_pkg::ST_OUTPUT) && (!rsp_valid_ff || !rsp_stall);
   end

   // datapath
   always_comb begin
      pred_sum = {1'b0, cov_ff[axis_ff]} + {1'b0, q_ff[axis_sel]};
      p_pred   = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
      den      = {1'b0, p_ff} + {1'b0, r_ff[axis_sel]};
      diff     = {z_ff[axis_sel][DW-1], z_ff[axis_sel]} - {est_ff[axis_ff][DW-1], est_ff[axis_ff]};
      k_comp   = pkf_pkg::GAIN_W'(pkf_pkg::ONE_Q16) - k_ff;
      if (mul_cov) begin
         mul_a = {1'b0, k_comp};
         mul_b = {2'b00, p_ff};
      end else begin
         mul_a = {1'b0, k_ff};
         mul_b = {diff[DW], diff};
      end
      product = mul_a * mul_b;
      rounded = prod_ff + 52'sd32768;
      corr    = rounded[51:16];
      est_sum = {{5{est_ff[axis_ff][DW-1]}}, est_ff[axis_ff]} + {corr[35], corr};

      vel_cur = vel_sel_ff ? pose[1] : pose[0];
      vel_old = vel_sel_ff ? old_y_ff : old_x_ff;
      delta   = {vel_cur[DW-1], vel_cur} - {vel_old[DW-1], vel_old};
      mag     = delta[DW] ? (~delta + 1'b1) : delta;
      if (div_cmd.long_mode) begin
         div_dvd = {mag, 16'h0000};
         div_dsr = {1'b0, ts_ff};
      end else begin
         div_dvd = {1'b0, p_ff, 16'h0000};
         div_dsr = den;
      end

      if (vel_zero_ff) begin
         vel_val = '0;
      end else if (div_sts.overflow) begin
         vel_val = vel_neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (!vel_neg_ff) begin
         vel_val = div_quo[DW-1] ? 32'sh7FFF_FFFF : div_quo;
      end else begin
         vel_val = (div_quo > 32'h8000_0000) ? 32'sh8000_0000 : (~div_quo + 1'b1);
      end

      dx   = {pose[0][DW-1], pose[0]} - {old_x_ff[DW-1], old_x_ff};
      dy   = {pose[1][DW-1], pose[1]} - {old_y_ff[DW-1], old_y_ff};
      dsum = {dx[DW], dx} + {dy[DW], dy};
   end

   pkf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         vel_sel_ff   <= 1'b0;
         ts_ff        <= pkf_pkg::ONE_Q16;
         time_acc_ff  <= '0;
         for (int i = 0; i < pkf_pkg::AXES_MAX; i++) begin
            q_ff[i] <= pkf_pkg::ONE_Q16;
            r_ff[i] <= pkf_pkg::ONE_Q16;
         end
         for (int i = 0; i < AXES; i++) begin
            est_ff[i] <= '0;
            cov_ff[i] <= pkf_pkg::ONE_Q16;
         end
      end else begin
         state_ff <= state_in;
         if (ld_rsp) begin
            rsp_valid_ff <= 1'b1;
            time_acc_ff  <= time_acc_ff + {16'h0000, ts_ff};
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               pkf_pkg::REG_Q_POS_X:   q_ff[0] <= csr_wdata;
               pkf_pkg::REG_Q_POS_Y:   q_ff[1] <= csr_wdata;
               pkf_pkg::REG_Q_HEADING: q_ff[2] <= csr_wdata;
               pkf_pkg::REG_R_POS_X:   r_ff[0] <= csr_wdata;
               pkf_pkg::REG_R_POS_Y:   r_ff[1] <= csr_wdata;
               pkf_pkg::REG_R_HEADING: r_ff[2] <= csr_wdata;
               pkf_pkg::REG_TIME_STEP: ts_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            axis_ff    <= '0;
            vel_sel_ff <= 1'b0;
         end
         if (ld_est) begin
            est_ff[axis_ff] <= pkf_pkg::sat_s32({{3{est_sum[36]}}, est_sum});
         end
         if (ld_cov) begin
            cov_ff[axis_ff] <= prod_ff[47:16];
            if (!last_axis) begin
               axis_ff <= axis_ff + 1'b1;
            end
         end
         if (ld_vel) begin
            vel_sel_ff <= 1'b1;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         z_ff[0]  <= req_meas_x;
         z_ff[1]  <= req_meas_y;
         z_ff[2]  <= req_meas_heading;
         old_x_ff <= pose[0];
         old_y_ff <= pose[1];
      end
      if (ld_p) begin
         p_ff <= p_pred;
      end
      if (div_cmd.start && !div_cmd.long_mode) begin
         den_zero_ff <= (den == '0);
      end
      if (div_cmd.start && div_cmd.long_mode) begin
         vel_neg_ff  <= delta[DW];
         vel_zero_ff <= (delta == '0);
      end
      if (ld_k) begin
         k_ff <= den_zero_ff ? '0 : div_quo[pkf_pkg::GAIN_W-1:0];
      end
      if (ld_prod) begin
         prod_ff <= product;
      end
      if (ld_vel) begin
         vel_ff[vel_sel_ff] <= vel_val;
      end
      if (ld_rsp) begin
         rsp_est_x       <= pose[0];
         rsp_est_y       <= pose[1];
         rsp_est_heading <= pose[2];
         rsp_vel_x       <= vel_ff[0];
         rsp_vel_y       <= vel_ff[1];
         rsp_disp_sum    <= pkf_pkg::sat_s32({{6{dsum[DW+1]}}, dsum});
         rsp_elapsed     <= time_acc_ff + {16'h0000, ts_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: sv/pkf_checker.sv
// Port-level checker of the pose Kalman filter and its bind.
`default_nettype none
`include "assert_macros.svh"

module pkf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [pkf_pkg::DATA_W-1:0]        rsp_est_x,
   input wire logic [pkf_pkg::ELAPSED_W-1:0]     rsp_elapsed
);

   `PKF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp item dropped while stalled")
   `PKF_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_est_x) && $stable(rsp_elapsed), "stalled rsp item changed")
   `PKF_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "second item taken while busy")
   `PKF_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "rsp item without work in flight")

endmodule

bind pose_kalman_filter pkf_checker u_pkf_checker (.*);

`default_nettype wire

FILE: tb/pose_kalman_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the pose Kalman filter against a fixed point filter model.

module pose_kalman_filter_tb;

   localparam int AXES_USED = pkf_pkg::AXES_DEF;
   localparam int REG_COUNT = 7;
   localparam logic [pkf_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int RANDOM_PHASES = 6;
   localparam int FIXES_PER_PHASE = 265;
   localparam int SETTLE_CYCLES = 160;
   localparam longint Q16_ONE = 65536;
   localparam logic signed [pkf_pkg::DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [pkf_pkg::DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [pkf_pkg::DATA_W-1:0] x;
      logic signed [pkf_pkg::DATA_W-1:0] y;
      logic signed [pkf_pkg::DATA_W-1:0] heading;
   } beacon_fix_type;

   typedef struct packed {
      logic signed [pkf_pkg::DATA_W-1:0] est_x;
      logic signed [pkf_pkg::DATA_W-1:0] est_y;
      logic signed [pkf_pkg::DATA_W-1:0] est_heading;
      logic signed [pkf_pkg::DATA_W-1:0] vel_x;
      logic signed [pkf_pkg::DATA_W-1:0] vel_y;
      logic signed [pkf_pkg::DATA_W-1:0] disp_sum;
      logic [pkf_pkg::ELAPSED_W-1:0]     elapsed;
   } pose_report_type;

   typedef logic [REG_COUNT-1:0][pkf_pkg::DATA_W-1:0] csr_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [pkf_pkg::DATA_W-1:0] req_meas_x = '0;
   logic signed [pkf_pkg::DATA_W-1:0] req_meas_y = '0;
   logic signed [pkf_pkg::DATA_W-1:0] req_meas_heading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_est_x;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_est_y;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_est_heading;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_vel_x;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_vel_y;
   logic signed [pkf_pkg::DATA_W-1:0] rsp_disp_sum;
   logic [pkf_pkg::ELAPSED_W-1:0] rsp_elapsed;
   logic csr_we = 1'b0;
   logic [pkf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pkf_pkg::DATA_W-1:0] csr_wdata = '0;

   logic signed [pkf_pkg::DATA_W-1:0] model_est [pkf_pkg::AXES_MAX];
   logic [pkf_pkg::DATA_W-1:0] model_cov [pkf_pkg::AXES_MAX];
   logic [pkf_pkg::ELAPSED_W-1:0] model_time;
   logic [pkf_pkg::DATA_W-1:0] csr_shadow [REG_COUNT];

   beacon_fix_type fixes_pending [$];
   pose_report_type poses_due [$];
   int fixes_queued = 0;
   int fixes_taken = 0;
   int mismatch_count = 0;
   int track_pos [pkf_pkg::AXES_MAX] = '{0, 0, 0};
   int unsigned send_idle_pct = 27;
   int unsigned recv_idle_pct = 71;
   logic req_fire = 1'b0;

   pose_kalman_filter #(.AXES(AXES_USED)) i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [pkf_pkg::DATA_W-1:0] clamp_s32(longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[pkf_pkg::DATA_W-1:0];
   endfunction

   function automatic logic signed [pkf_pkg::DATA_W-1:0] rate_of(longint delta,
                                                                 logic [pkf_pkg::DATA_W-1:0] step);
      if (step == 0) begin
         if (delta > 0) return S32_MAX;
         if (delta < 0) return S32_MIN;
         return '0;
      end
      return clamp_s32((delta * Q16_ONE) / longint'(step));
   endfunction

   function automatic void update_axis(int axis, logic signed [pkf_pkg::DATA_W-1:0] z);
      longint unsigned p_pred;
      longint unsigned den;
      longint unsigned gain;
      longint diff;
      longint corr;
      p_pred = 64'(model_cov[axis]) + 64'(csr_shadow[pkf_pkg::REG_Q_POS_X + axis]);
      if (p_pred > 64'hFFFF_FFFF) p_pred = 64'hFFFF_FFFF;
      den = p_pred + 64'(csr_shadow[pkf_pkg::REG_R_POS_X + axis]);
      gain = (den == 0) ? 64'd0 : (p_pred * Q16_ONE) / den;
      diff = longint'(z) - longint'(model_est[axis]);
      // round half up: floor of (k * d + 0.5)
      corr = (longint'(gain) * diff + Q16_ONE / 2) >>> 16;
      model_est[axis] = clamp_s32(longint'(model_est[axis]) + corr);
      model_cov[axis] = pkf_pkg::DATA_W'(((Q16_ONE - gain) * p_pred) / Q16_ONE);
   endfunction

   function automatic pose_report_type predict_report(beacon_fix_type fix);
      pose_report_type r;
      logic signed [pkf_pkg::DATA_W-1:0] zs [pkf_pkg::AXES_MAX];
      logic signed [pkf_pkg::DATA_W-1:0] old_x;
      logic signed [pkf_pkg::DATA_W-1:0] old_y;
      longint dx;
      longint dy;
      zs[0] = fix.x;
      zs[1] = fix.y;
      zs[2] = fix.heading;
      old_x = model_est[0];
      old_y = model_est[1];
      for (int a = 0; a < AXES_USED; a++) update_axis(a, zs[a]);
      dx = longint'(model_est[0]) - longint'(old_x);
      dy = longint'(model_est[1]) - longint'(old_y);
      model_time = model_time + csr_shadow[pkf_pkg::REG_TIME_STEP];
      r.est_x = model_est[0];
      r.est_y = model_est[1];
      r.est_heading = model_est[2];
      r.vel_x = rate_of(dx, csr_shadow[pkf_pkg::REG_TIME_STEP]);
      r.vel_y = rate_of(dy, csr_shadow[pkf_pkg::REG_TIME_STEP]);
      r.disp_sum = clamp_s32(dx + dy);
      r.elapsed = model_time;
      return r;
   endfunction

   function automatic beacon_fix_type next_fix();
      beacon_fix_type f;
      logic signed [pkf_pkg::DATA_W-1:0] v [pkf_pkg::AXES_MAX];
      int unsigned mode;
      mode = $urandom_range(99);
      for (int a = 0; a < pkf_pkg::AXES_MAX; a++) begin
         if (mode < 60) begin
            // smooth track with measurement noise
            track_pos[a] = track_pos[a] + int'($urandom_range(131072)) - 65536;
            v[a] = track_pos[a] + int'($urandom_range(8191)) - 4096;
         end else if (mode < 85) begin
            v[a] = $urandom;
         end else begin
            case ($urandom_range(3))
               0: v[a] = S32_MAX;
               1: v[a] = S32_MIN;
               2: v[a] = '0;
               default: v[a] = '1;
            endcase
         end
      end
      f.x = v[0];
      f.y = v[1];
      f.heading = v[2];
      return f;
   endfunction

   function automatic logic [pkf_pkg::DATA_W-1:0] pick_reg(bit zero_ok);
      case ($urandom_range(5))
         0: return zero_ok ? 32'd0 : 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(32'h0004_0000, 1);
      endcase
   endfunction

   task automatic queue_fix(beacon_fix_type f);
      fixes_pending.push_back(f);
      fixes_queued++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (fixes_taken != fixes_queued || poses_due.size() != 0) @(negedge clock);
   endtask

   task automatic load_config(csr_set_type vals);
      for (int i = 0; i < REG_COUNT; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= pkf_pkg::CSR_IDX_W'(i);
         csr_wdata <= vals[i];
      end
      // unmapped index: must be dropped
      @(negedge clock);
      csr_index <= REG_UNMAPPED;
      csr_wdata <= $urandom;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin : drive_req
      beacon_fix_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (fixes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            head = fixes_pending.pop_front();
            req_meas_x <= head.x;
            req_meas_y <= head.y;
            req_meas_heading <= head.heading;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : watch_dut
      pose_report_type want;
      pose_report_type got;
      if (reset) begin
         for (int a = 0; a < pkf_pkg::AXES_MAX; a++) begin
            model_est[a] = '0;
            model_cov[a] = pkf_pkg::ONE_Q16;
         end
         model_time = '0;
         for (int i = 0; i < REG_COUNT; i++) csr_shadow[i] = pkf_pkg::ONE_Q16;
         req_fire <= 1'b0;
      end else begin
         if (csr_we && csr_index <= pkf_pkg::REG_TIME_STEP) csr_shadow[csr_index] = csr_wdata;
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            poses_due.push_back(predict_report({req_meas_x, req_meas_y, req_meas_heading}));
            fixes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_est_x, rsp_est_y, rsp_est_heading, rsp_vel_x, rsp_vel_y,
                   rsp_disp_sum, rsp_elapsed};
            if (poses_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h", $time, got);
               mismatch_count++;
            end else begin
               want = poses_due.pop_front();
               check_field("est_x", want.est_x, got.est_x);
               check_field("est_y", want.est_y, got.est_y);
               check_field("est_heading", want.est_heading, got.est_heading);
               check_field("vel_x", want.vel_x, got.vel_x);
               check_field("vel_y", want.vel_y, got.vel_y);
               check_field("disp_sum", want.disp_sum, got.disp_sum);
               check_field("elapsed", want.elapsed, got.elapsed);
            end
         end
      end
   end

   initial begin : stimulus
      csr_set_type cfg;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration, field extremes
      queue_fix({32'sd0, 32'sd0, 32'sd0});
      queue_fix({S32_MAX, S32_MAX, S32_MAX});
      queue_fix({S32_MIN, S32_MIN, S32_MIN});
      queue_fix({S32_MAX, S32_MIN, S32_MAX});
      queue_fix({S32_MIN, S32_MAX, S32_MIN});
      queue_fix({32'sd1, -32'sd1, 32'sh0001_0000});
      queue_fix({32'shFFFF_FFFF, 32'sd0, 32'sh5555_5555});
      queue_fix({32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA});

      // zero time step: rising, falling and unchanged estimate; saturated predict
      wait_idle();
      cfg[pkf_pkg::REG_Q_POS_X] = '1;
      cfg[pkf_pkg::REG_Q_POS_Y] = '1;
      cfg[pkf_pkg::REG_Q_HEADING] = '1;
      cfg[pkf_pkg::REG_R_POS_X] = '1;
      cfg[pkf_pkg::REG_R_POS_Y] = '1;
      cfg[pkf_pkg::REG_R_HEADING] = '1;
      cfg[pkf_pkg::REG_TIME_STEP] = '0;
      load_config(cfg);
      queue_fix({32'sh1000_0000, 32'sh1000_0000, 32'sh1000_0000});
      queue_fix({-32'sh2000_0000, -32'sh2000_0000, -32'sh2000_0000});
      wait_idle();
      queue_fix({model_est[0], model_est[1], model_est[2]});

      // zero noise: full gain, then a zero gain denominator
      wait_idle();
      cfg[pkf_pkg::REG_Q_POS_X] = '0;
      cfg[pkf_pkg::REG_Q_POS_Y] = '0;
      cfg[pkf_pkg::REG_Q_HEADING] = '0;
      cfg[pkf_pkg::REG_R_POS_X] = '0;
      cfg[pkf_pkg::REG_R_POS_Y] = '0;
      cfg[pkf_pkg::REG_R_HEADING] = '0;
      cfg[pkf_pkg::REG_TIME_STEP] = '1;
      load_config(cfg);
      queue_fix({32'sh1234_5678, S32_MIN, S32_MAX});
      queue_fix({S32_MAX, S32_MIN, 32'sd0});
      queue_fix({32'sd0, 32'sd0, 32'sd0});

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         send_idle_pct = (phase < 2) ? 27 : (phase < 4) ? 71 : 0;
         recv_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 27 : 0;
         if (phase == 1) begin
            // highest gain, finest time step
            cfg[pkf_pkg::REG_Q_POS_X] = '1;
            cfg[pkf_pkg::REG_Q_POS_Y] = '1;
            cfg[pkf_pkg::REG_Q_HEADING] = '1;
            cfg[pkf_pkg::REG_R_POS_X] = 32'd1;
            cfg[pkf_pkg::REG_R_POS_Y] = 32'd1;
            cfg[pkf_pkg::REG_R_HEADING] = 32'd1;
            cfg[pkf_pkg::REG_TIME_STEP] = 32'd1;
         end else if (phase == 2) begin
            // lowest gain, coarsest time step
            cfg[pkf_pkg::REG_Q_POS_X] = '0;
            cfg[pkf_pkg::REG_Q_POS_Y] = '0;
            cfg[pkf_pkg::REG_Q_HEADING] = '0;
            cfg[pkf_pkg::REG_R_POS_X] = '1;
            cfg[pkf_pkg::REG_R_POS_Y] = '1;
            cfg[pkf_pkg::REG_R_HEADING] = '1;
            cfg[pkf_pkg::REG_TIME_STEP] = '1;
         end else begin
            for (int i = 0; i < REG_COUNT; i++) cfg[i] = pick_reg(i < pkf_pkg::REG_R_POS_X);
         end
         load_config(cfg);
         repeat (FIXES_PER_PHASE) queue_fix(next_fix());
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (poses_due.size() != 0) begin
         $display("%0t: leftover items, expected 0, actual %0d", $time, poses_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
